// ----- hdl/tcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Payload types, codes and the command/status bundles shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Results per input transaction are capped; later ones are dropped.
  localparam int RESULT_CAP = 8;
  localparam int CNT_W      = 4;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] KIND_DRAW   = 2'd0;
  localparam logic [1:0] KIND_SCROLL = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  localparam logic [7:0] COLUMNS_RST = 8'd79;
  localparam logic [6:0] ROWS_RST    = 7'd39;

  typedef struct packed {
    logic        op;
    logic [7:0]  char_code;
    logic [31:0] bg_color;
    logic [31:0] fg_color;
    logic [6:0]  read_col;
    logic [5:0]  read_row;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  cell_col;
    logic [5:0]  cell_row;
    logic [7:0]  cell_char;
    logic [31:0] cell_bg;
    logic [31:0] cell_fg;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic       index;
    logic [7:0] value;
  } cfg_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic clamp;
    logic col_zero;
    logic newline;
    logic col_dec;
    logic advance;
    logic scr_last;
    logic tab_load;
    logic tab_dec;
    logic map_rd_rr;
    logic map_rd_cur;
    logic map_rd_zero;
    logic map_rd_next;
    logic map_wr_shift;
    logic phys_load;
    logic st_rd;
    logic rd_capture;
    logic rd_space;
    logic sweep_init;
    logic sweep_wr;
    logic char_wr;
    logic scr_init;
    logic scr_inc;
    logic tmp_load;
    logic emit_draw;
    logic emit_scroll;
    logic emit_read;
    logic flush;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_read;
    logic rd_oob;
    logic is_cr;
    logic is_lf;
    logic is_bs;
    logic is_tab;
    logic col_zero;
    logic row_valid;
    logic sweep_last;
    logic scr_need;
    logic scr_end;
    logic tab_more;
    logic emit_ok;
    logic pend_valid;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- hdl/tcc_chan_if.sv -----
// ----------------------------------------------------------------------------
// Valid/ready channel
// One transaction moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface tcc_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/text_console_cursor_engine.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine
// Character grid with a cursor: puts characters and control codes, scrolls,
// and reads back stored cells, reporting draw, scroll and read results.
// ----------------------------------------------------------------------------
//
// Channel  Role   Payload               Notes
// -------  -----  --------------------  -------------------------------------
// req      sink   tcc_pkg::in_item_t    put character or read one cell
// rsp      source tcc_pkg::out_item_t   results, last set on the final one
// cfg      sink   tcc_pkg::cfg_item_t   index 0 columns, 1 rows; always ready
//
// An ordinary character passes through map lookup, store write and the scroll
// check before the next ready, a read through map lookup and store read, and a
// carriage return only zeroes the column. The first character drawn into a
// blank row first fills that row of the store with spaces, a scroll rewrites
// the row map, and a tab repeats the character sequence once per space.
// Reset is synchronous; there is no clearing pass: all rows start blank.
// A stalled rsp holds one result in the output register and one in a holding
// register; the engine waits only when both are full.
//
module text_console_cursor_engine #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64,
  parameter int TAB_STOP = 4
) (
  input logic        clk,
  input logic        rst,
  tcc_chan_if.sink   req,
  tcc_chan_if.source rsp,
  tcc_chan_if.sink   cfg
);

  tcc_pkg::dp_cmd_t cmd;
  tcc_pkg::dp_sts_t sts;
  logic             ctrl_ready;

  // The controller walks each put through map lookup, row fill, store write and
  // scroll, and each read through map and store reads; the datapath owns the results.
  tcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ctrl_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tcc_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (req.data),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.data),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp.data)
  );

  // New work is taken only when the controller is idle.
  assign req.ready = ctrl_ready;
  // Register writes are always taken; the user must write only while the engine idles: not enforced.
  assign cfg.ready = 1'b1;

  // No result may be left in the holding register once the engine is idle.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    ctrl_ready |-> !sts.pend_valid)
    else $error("result still held while idle");

  // An accepted transaction keeps the engine busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && ctrl_ready) |=> !ctrl_ready)
    else $error("ready after accept");

  // A result is produced only when there is room for it.
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_draw || cmd.emit_scroll || cmd.emit_read) |-> sts.emit_ok)
    else $error("result produced without room");

  // The row fill and the character write never share the store write port.
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(cmd.sweep_wr && cmd.char_wr))
    else $error("two store writers");

endmodule

// ----- hdl/tcc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module tcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

// ----- hdl/tcc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Cursor engine controller
// Sequences one transaction at a time through the datapath.
// ----------------------------------------------------------------------------
module tcc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output tcc_pkg::dp_cmd_t cmd,
  input  tcc_pkg::dp_sts_t sts
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_RD_MAP  = 5'd2;
  localparam logic [4:0] S_RD_DATA = 5'd3;
  localparam logic [4:0] S_RD_EMIT = 5'd4;
  localparam logic [4:0] S_CLASS   = 5'd5;
  localparam logic [4:0] S_MAP     = 5'd6;
  localparam logic [4:0] S_MAP_W   = 5'd7;
  localparam logic [4:0] S_ROWCHK  = 5'd8;
  localparam logic [4:0] S_CLEAR   = 5'd9;
  localparam logic [4:0] S_WRITE   = 5'd10;
  localparam logic [4:0] S_CHK     = 5'd11;
  localparam logic [4:0] S_SC0     = 5'd12;
  localparam logic [4:0] S_SC1     = 5'd13;
  localparam logic [4:0] S_SC_CHK  = 5'd14;
  localparam logic [4:0] S_SC2     = 5'd15;
  localparam logic [4:0] S_SC_LAST = 5'd16;
  localparam logic [4:0] S_NEXT    = 5'd17;
  localparam logic [4:0] S_FIN     = 5'd18;

  logic [4:0] state;
  logic [4:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.is_read) begin
          if (sts.rd_oob) begin
            cmd.rd_space = 1'b1;
            state_next   = S_RD_EMIT;
          end else begin
            cmd.map_rd_rr = 1'b1;
            state_next    = S_RD_MAP;
          end
        end else begin
          cmd.clamp  = 1'b1;
          state_next = S_CLASS;
        end
      end
      S_RD_MAP: begin
        cmd.st_rd     = 1'b1;
        cmd.phys_load = 1'b1;
        state_next    = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd.rd_capture = 1'b1;
        state_next     = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        if (sts.emit_ok) begin
          cmd.emit_read = 1'b1;
          state_next    = S_FIN;
        end
      end
      S_CLASS: begin
        if (sts.is_cr) begin
          cmd.col_zero = 1'b1;
          state_next   = S_FIN;
        end else if (sts.is_lf) begin
          cmd.newline = 1'b1;
          state_next  = S_CHK;
        end else if (sts.is_bs) begin
          if (sts.col_zero) begin
            state_next = S_FIN;
          end else begin
            cmd.col_dec = 1'b1;
            state_next  = S_MAP;
          end
        end else if (sts.is_tab) begin
          cmd.tab_load = 1'b1;
          state_next   = S_MAP;
        end else begin
          state_next = S_MAP;
        end
      end
      S_MAP: begin
        cmd.map_rd_cur = 1'b1;
        state_next     = S_MAP_W;
      end
      S_MAP_W: begin
        cmd.phys_load = 1'b1;
        state_next    = S_ROWCHK;
      end
      S_ROWCHK: begin
        if (sts.row_valid) begin
          state_next = S_WRITE;
        end else begin
          cmd.sweep_init = 1'b1;
          state_next     = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        // The store write is repeated while the result waits; it is idempotent.
        cmd.char_wr = 1'b1;
        if (sts.emit_ok) begin
          cmd.emit_draw = 1'b1;
          if (sts.is_bs) begin
            state_next = S_FIN;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_CHK;
          end
        end
      end
      S_CHK: begin
        state_next = sts.scr_need ? S_SC0 : S_NEXT;
      end
      S_SC0: begin
        cmd.map_rd_zero = 1'b1;
        cmd.scr_init    = 1'b1;
        state_next      = S_SC1;
      end
      S_SC1: begin
        cmd.tmp_load = 1'b1;
        state_next   = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (sts.scr_end) begin
          state_next = S_SC_LAST;
        end else begin
          cmd.map_rd_next = 1'b1;
          state_next      = S_SC2;
        end
      end
      S_SC2: begin
        cmd.map_wr_shift = 1'b1;
        cmd.scr_inc      = 1'b1;
        state_next       = S_SC_CHK;
      end
      S_SC_LAST: begin
        cmd.scr_last = 1'b1;
        if (sts.emit_ok) begin
          cmd.emit_scroll = 1'b1;
          state_next      = S_NEXT;
        end
      end
      S_NEXT: begin
        if (sts.is_tab && sts.tab_more) begin
          cmd.tab_dec = 1'b1;
          state_next  = S_MAP;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.pend_valid) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/tcc_dp.sv -----
// ----------------------------------------------------------------------------
// Cursor engine datapath
// Configuration registers, cursor, row map, character store and the
// result holding and output registers.
// ----------------------------------------------------------------------------
module tcc_dp #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64,
  parameter int TAB_STOP = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  tcc_pkg::dp_cmd_t   cmd,
  output tcc_pkg::dp_sts_t   sts,
  input  tcc_pkg::in_item_t  in_data,
  input  logic               cfg_valid,
  input  tcc_pkg::cfg_item_t cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tcc_pkg::out_item_t out_data
);

  localparam int CAW    = $clog2(MAX_COLS);
  localparam int RAW    = $clog2(MAX_ROWS);
  localparam int CW     = $clog2(MAX_COLS + 1);
  localparam int RW     = $clog2(MAX_ROWS + 1);
  localparam int TW     = $clog2(TAB_STOP + 1);
  localparam int SDEPTH = MAX_ROWS * (2 ** CAW);

  logic [7:0]              columns;
  logic [6:0]              rows;
  logic [CW-1:0]           cur_col;
  logic [RW-1:0]           cur_row;
  tcc_pkg::in_item_t       item;
  logic [TW-1:0]           tab_left;
  logic [CAW-1:0]          sw_col;
  logic [RAW-1:0]          scr_i;
  logic [RAW-1:0]          tmp_phys;
  logic [RAW-1:0]          phys;
  logic [RAW-1:0]          map_rd_idx;
  logic                    map_rd_vld;
  logic [MAX_ROWS-1:0]     row_vld;
  logic [MAX_ROWS-1:0]     map_vld;
  logic [tcc_pkg::CNT_W-1:0] res_cnt;
  tcc_pkg::out_item_t      pend;
  tcc_pkg::out_item_t      out_r;
  logic                    pend_valid;
  logic                    out_valid_r;
  logic [7:0]              read_char;

  logic [CW-1:0]  cols_w;
  logic [RW-1:0]  rows_h;
  logic [CW-1:0]  col_inc;
  logic [RAW-1:0] h_m1;
  logic [RAW-1:0] map_q;
  logic [RAW-1:0] map_phys;
  logic           map_re;
  logic [RAW-1:0] map_raddr;
  logic           map_we;
  logic [RAW-1:0] map_waddr;
  logic [RAW-1:0] map_wdata;
  logic           st_we;
  logic [RAW+CAW-1:0] st_waddr;
  logic [7:0]     st_wdata;
  logic [7:0]     st_q;
  logic [7:0]     put_char;
  logic           emit_any;
  logic           cnt_full;
  logic           out_free;
  tcc_pkg::out_item_t new_res;
  logic [TW-1:0]  tab_len [MAX_COLS];

  // Spaces to the next tab stop, one entry per column.
  for (genvar g = 0; g < MAX_COLS; g++) begin : g_tab
    assign tab_len[g] = TW'(TAB_STOP - (g % TAB_STOP));
  end

  // Register values out of range act as the nearest legal width or height.
  always_comb begin
    if (columns == 8'd0) begin
      cols_w = CW'(1);
    end else if (int'(columns) > MAX_COLS) begin
      cols_w = CW'(MAX_COLS);
    end else begin
      cols_w = CW'(columns);
    end
    if (rows == 7'd0) begin
      rows_h = RW'(1);
    end else if (int'(rows) > MAX_ROWS) begin
      rows_h = RW'(MAX_ROWS);
    end else begin
      rows_h = RW'(rows);
    end
  end

  assign col_inc  = cur_col + CW'(1);
  assign h_m1     = RAW'(rows_h - RW'(1));
  assign map_phys = map_rd_vld ? map_q : map_rd_idx;
  assign put_char = (sts.is_tab || sts.is_bs) ? tcc_pkg::CH_SPACE : item.char_code;
  assign emit_any = cmd.emit_draw | cmd.emit_scroll | cmd.emit_read;
  assign cnt_full = (res_cnt == tcc_pkg::CNT_W'(tcc_pkg::RESULT_CAP));
  assign out_free = !out_valid_r || out_ready;

  // Row map: logical row to physical row of the store. Unwritten entries
  // map a row onto itself.
  always_comb begin
    map_re    = 1'b1;
    map_raddr = '0;
    if (cmd.map_rd_rr) begin
      map_raddr = RAW'(item.read_row);
    end else if (cmd.map_rd_cur) begin
      map_raddr = cur_row[RAW-1:0];
    end else if (cmd.map_rd_next) begin
      map_raddr = scr_i + RAW'(1);
    end else if (!cmd.map_rd_zero) begin
      map_re = 1'b0;
    end
    map_we    = cmd.map_wr_shift | cmd.scr_last;
    map_waddr = cmd.scr_last ? h_m1 : scr_i;
    map_wdata = cmd.scr_last ? tmp_phys : map_phys;
  end

  tcc_ram #(.WIDTH(RAW), .DEPTH(MAX_ROWS)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .q     (map_q)
  );

  assign st_we    = cmd.sweep_wr | cmd.char_wr;
  assign st_waddr = cmd.sweep_wr ? {phys, sw_col} : {phys, cur_col[CAW-1:0]};
  assign st_wdata = cmd.sweep_wr ? tcc_pkg::CH_SPACE : put_char;

  tcc_ram #(.WIDTH(8), .DEPTH(SDEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (cmd.st_rd),
    .raddr ({map_phys, CAW'(item.read_col)}),
    .q     (st_q)
  );

  always_comb begin
    new_res = '0;
    if (cmd.emit_draw) begin
      new_res.kind      = tcc_pkg::KIND_DRAW;
      new_res.cell_col  = 7'(cur_col);
      new_res.cell_row  = 6'(cur_row);
      new_res.cell_char = put_char;
      new_res.cell_bg   = item.bg_color;
      new_res.cell_fg   = item.fg_color;
    end else if (cmd.emit_read) begin
      new_res.kind      = tcc_pkg::KIND_READ;
      new_res.cell_col  = item.read_col;
      new_res.cell_row  = item.read_row;
      new_res.cell_char = read_char;
    end else begin
      new_res.kind      = tcc_pkg::KIND_SCROLL;
    end
  end

  always_comb begin
    sts.is_read    = (item.op == tcc_pkg::OP_READ);
    sts.rd_oob     = (int'(item.read_col) >= MAX_COLS) || (int'(item.read_row) >= MAX_ROWS);
    sts.is_cr      = (item.char_code == tcc_pkg::CH_CR);
    sts.is_lf      = (item.char_code == tcc_pkg::CH_LF);
    sts.is_bs      = (item.char_code == tcc_pkg::CH_BS) || (item.char_code == tcc_pkg::CH_DEL);
    sts.is_tab     = (item.char_code == tcc_pkg::CH_TAB);
    sts.col_zero   = (cur_col == '0);
    sts.row_valid  = row_vld[phys];
    sts.sweep_last = (sw_col == CAW'(MAX_COLS - 1));
    sts.scr_need   = (cur_row >= rows_h);
    sts.scr_end    = (scr_i == h_m1);
    sts.tab_more   = (tab_left > TW'(1));
    sts.emit_ok    = cnt_full || !pend_valid || out_free;
    sts.pend_valid = pend_valid;
    sts.out_free   = out_free;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      columns     <= tcc_pkg::COLUMNS_RST;
      rows        <= tcc_pkg::ROWS_RST;
      cur_col     <= '0;
      cur_row     <= '0;
      row_vld     <= '0;
      map_vld     <= '0;
      res_cnt     <= '0;
      pend_valid  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_data.index)
          tcc_pkg::CFG_COLUMNS: columns <= cfg_data.value;
          tcc_pkg::CFG_ROWS:    rows    <= cfg_data.value[6:0];
          default: ;
        endcase
      end

      if (cmd.clamp) begin
        if (cur_col >= cols_w) cur_col <= cols_w - CW'(1);
        if (cur_row >= rows_h) cur_row <= rows_h - RW'(1);
      end else if (cmd.col_zero) begin
        cur_col <= '0;
      end else if (cmd.newline) begin
        cur_col <= '0;
        cur_row <= cur_row + RW'(1);
      end else if (cmd.col_dec) begin
        cur_col <= cur_col - CW'(1);
      end else if (cmd.advance) begin
        if (col_inc >= cols_w) begin
          cur_col <= '0;
          cur_row <= cur_row + RW'(1);
        end else begin
          cur_col <= col_inc;
        end
      end else if (cmd.scr_last) begin
        cur_row <= RW'(h_m1);
      end

      if (map_we) begin
        map_vld[map_waddr] <= 1'b1;
      end
      // A row finished by a sweep holds spaces; the row scrolled to the
      // bottom reads as blank until something is drawn into it.
      if (cmd.sweep_wr && sts.sweep_last) begin
        row_vld[phys] <= 1'b1;
      end
      if (cmd.scr_last) begin
        row_vld[tmp_phys] <= 1'b0;
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load) begin
        res_cnt <= '0;
      end
      if (emit_any && !cnt_full) begin
        pend_valid <= 1'b1;
        res_cnt    <= res_cnt + tcc_pkg::CNT_W'(1);
        if (pend_valid) begin
          out_valid_r <= 1'b1;
        end
      end
      if (cmd.flush) begin
        pend_valid  <= 1'b0;
        out_valid_r <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
    if (cmd.tab_load) begin
      tab_left <= tab_len[cur_col[CAW-1:0]];
    end else if (cmd.tab_dec) begin
      tab_left <= tab_left - TW'(1);
    end
    if (cmd.sweep_init) begin
      sw_col <= '0;
    end else if (cmd.sweep_wr) begin
      sw_col <= sw_col + CAW'(1);
    end
    if (cmd.scr_init) begin
      scr_i <= '0;
    end else if (cmd.scr_inc) begin
      scr_i <= scr_i + RAW'(1);
    end
    if (cmd.tmp_load) begin
      tmp_phys <= map_phys;
    end
    if (cmd.phys_load) begin
      phys <= map_phys;
    end
    if (map_re) begin
      map_rd_idx <= map_raddr;
      map_rd_vld <= map_vld[map_raddr];
    end
    if (cmd.rd_space) begin
      read_char <= tcc_pkg::CH_SPACE;
    end else if (cmd.rd_capture) begin
      read_char <= row_vld[phys] ? st_q : tcc_pkg::CH_SPACE;
    end
    if (emit_any && !cnt_full) begin
      pend <= new_res;
      if (pend_valid) begin
        out_r <= pend;
      end
    end
    if (cmd.flush) begin
      out_r      <= pend;
      out_r.last <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- tb/tb_text_console_cursor_engine.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console cursor engine testbench
// Sends put and read requests and checks every draw, scroll and read result
// in order against a cycle-free prediction of the character grid and cursor.
// Grid geometry is changed between phases while the engine is idle.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_engine;

  // Geometry of the instance under test. The prediction uses the same values.
  localparam int GRID_COLS = 128;
  localparam int GRID_ROWS = 64;
  localparam int TAB_WIDTH = 4;

  // Worst item: a tab of four spaces, each filling a blank row and scrolling.
  // The limit covers that item with room to spare, plus the deliberate receiver
  // hold-off.
  localparam int QUIET_LIMIT   = 20000;
  // Cycles allowed after the last result before the engine counts as idle,
  // so that a trailing item with no result has finished too.
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES   = 600;
  localparam int IDLE_PERCENT  = 34;
  localparam int PRINT_LIMIT   = 60;

  logic clk;
  logic rst;

  tcc_chan_if #(.payload_t(tcc_pkg::in_item_t))  req_if ();
  tcc_chan_if #(.payload_t(tcc_pkg::out_item_t)) rsp_if ();
  tcc_chan_if #(.payload_t(tcc_pkg::cfg_item_t)) cfg_if ();

  text_console_cursor_engine #(
    .MAX_COLS(GRID_COLS),
    .MAX_ROWS(GRID_ROWS),
    .TAB_STOP(TAB_WIDTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  // --------------------------------------------------------------------------
  // Predicted state of the engine: the character grid, the cursor and the
  // two geometry registers as last written.
  // --------------------------------------------------------------------------
  logic [7:0] grid_chars [GRID_COLS*GRID_ROWS];
  int         cur_col;
  int         cur_row;
  logic [7:0] columns_reg;
  logic [6:0] rows_reg;

  tcc_pkg::out_item_t step_results [$];   // results of the item being predicted
  tcc_pkg::out_item_t expected_cells [$]; // results still owed by the engine

  int         mismatch_count;
  bit         no_idle;
  int         holds_requested;

  // --------------------------------------------------------------------------
  // Clock and reset.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction.
  // --------------------------------------------------------------------------

  // A zero register behaves as one; anything above the store size saturates.
  function automatic int used_cols();
    if (columns_reg == 0) return 1;
    return (columns_reg > GRID_COLS) ? GRID_COLS : int'(columns_reg);
  endfunction

  function automatic int used_rows();
    if (rows_reg == 0) return 1;
    return (rows_reg > GRID_ROWS) ? GRID_ROWS : int'(rows_reg);
  endfunction

  function automatic void clear_grid();
    foreach (grid_chars[i]) grid_chars[i] = tcc_pkg::CH_SPACE;
  endfunction

  // Queues one result for the current item. Beyond the cap results are lost,
  // while the grid and cursor keep changing.
  function automatic void add_result(logic [1:0] kind, int col, int row, logic [7:0] ch,
                                     logic [31:0] bg, logic [31:0] fg);
    tcc_pkg::out_item_t r;
    if (step_results.size() >= tcc_pkg::RESULT_CAP) return;
    r.kind      = kind;
    r.cell_col  = col[6:0];
    r.cell_row  = row[5:0];
    r.cell_char = ch;
    r.cell_bg   = bg;
    r.cell_fg   = fg;
    r.last      = 1'b0;
    step_results.push_back(r);
  endfunction

  // When the cursor has dropped below the last row in use, every row moves
  // up by one across the whole store width and the last row goes blank.
  function automatic void scroll_if_needed();
    int h;
    h = used_rows();
    if (cur_row < h) return;
    for (int r = 0; r < h - 1; r++)
      for (int c = 0; c < GRID_COLS; c++)
        grid_chars[r*GRID_COLS + c] = grid_chars[(r+1)*GRID_COLS + c];
    for (int c = 0; c < GRID_COLS; c++)
      grid_chars[(h-1)*GRID_COLS + c] = tcc_pkg::CH_SPACE;
    cur_row = h - 1;
    add_result(tcc_pkg::KIND_SCROLL, 0, 0, 8'h00, 32'h0, 32'h0);
  endfunction

  function automatic void print_char(logic [7:0] ch, logic [31:0] bg, logic [31:0] fg);
    grid_chars[cur_row*GRID_COLS + cur_col] = ch;
    add_result(tcc_pkg::KIND_DRAW, cur_col, cur_row, ch, bg, fg);
    cur_col++;
    if (cur_col >= used_cols()) begin
      cur_col = 0;
      cur_row++;
    end
    scroll_if_needed();
  endfunction

  // Works out everything one accepted request causes and appends it to the
  // queue of owed results, with last set on the final one.
  function automatic void predict_console_step(tcc_pkg::in_item_t it);
    int w;
    int h;
    int n;
    step_results.delete();
    w = used_cols();
    h = used_rows();
    if (it.op == tcc_pkg::OP_READ) begin
      // Read coordinates always fall inside the store, used area or not.
      add_result(tcc_pkg::KIND_READ, int'(it.read_col), int'(it.read_row),
                 grid_chars[int'(it.read_row)*GRID_COLS + int'(it.read_col)],
                 32'h0, 32'h0);
    end else begin
      // A cursor left outside a shrunken grid is pulled back first.
      if (cur_col >= w) cur_col = w - 1;
      if (cur_row >= h) cur_row = h - 1;
      case (it.char_code)
        tcc_pkg::CH_CR: cur_col = 0;
        tcc_pkg::CH_LF: begin
          cur_col = 0;
          cur_row++;
          scroll_if_needed();
        end
        tcc_pkg::CH_BS, tcc_pkg::CH_DEL: begin
          if (cur_col != 0) begin
            cur_col--;
            grid_chars[cur_row*GRID_COLS + cur_col] = tcc_pkg::CH_SPACE;
            add_result(tcc_pkg::KIND_DRAW, cur_col, cur_row, tcc_pkg::CH_SPACE,
                       it.bg_color, it.fg_color);
          end
        end
        tcc_pkg::CH_TAB: begin
          n = TAB_WIDTH - (cur_col % TAB_WIDTH);
          repeat (n) print_char(tcc_pkg::CH_SPACE, it.bg_color, it.fg_color);
        end
        default: print_char(it.char_code, it.bg_color, it.fg_color);
      endcase
    end
    if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
    foreach (step_results[i]) expected_cells.push_back(step_results[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Request builders. Fields the operation does not use still get random
  // values so that every input bit toggles.
  // --------------------------------------------------------------------------
  function automatic tcc_pkg::in_item_t make_put(logic [7:0] ch, logic [31:0] bg,
                                                 logic [31:0] fg);
    tcc_pkg::in_item_t it;
    it.op        = tcc_pkg::OP_PUT;
    it.char_code = ch;
    it.bg_color  = bg;
    it.fg_color  = fg;
    it.read_col  = 7'($urandom_range(0, 127));
    it.read_row  = 6'($urandom_range(0, 63));
    return it;
  endfunction

  function automatic tcc_pkg::in_item_t make_read(int col, int row);
    tcc_pkg::in_item_t it;
    it.op        = tcc_pkg::OP_READ;
    it.char_code = 8'($urandom_range(0, 255));
    it.bg_color  = $urandom;
    it.fg_color  = $urandom;
    it.read_col  = col[6:0];
    it.read_row  = row[5:0];
    return it;
  endfunction

  // Mostly printable bytes with a fair share of control codes and reads.
  // Reads favor the area in use, where the interesting contents are.
  function automatic tcc_pkg::in_item_t make_random_item();
    int pick;
    int col;
    int row;
    logic [7:0] ch;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      if ($urandom_range(0, 99) < 70) begin
        col = $urandom_range(0, used_cols() - 1);
        row = $urandom_range(0, used_rows() - 1);
      end else begin
        col = $urandom_range(0, 127);
        row = $urandom_range(0, 63);
      end
      return make_read(col, row);
    end
    pick = $urandom_range(0, 99);
    if (pick < 8)       ch = tcc_pkg::CH_CR;
    else if (pick < 18) ch = tcc_pkg::CH_LF;
    else if (pick < 26) ch = tcc_pkg::CH_BS;
    else if (pick < 30) ch = tcc_pkg::CH_DEL;
    else if (pick < 40) ch = tcc_pkg::CH_TAB;
    else                ch = 8'($urandom_range(0, 255));
    return make_put(ch, $urandom, $urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Checking and reporting.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Every result transaction is compared with the oldest owed result.
  always @(posedge clk) begin
    tcc_pkg::out_item_t got;
    tcc_pkg::out_item_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (expected_cells.size() == 0) begin
        report_mismatch("unexpected result kind", 32'(got.kind), 32'h0);
      end else begin
        want = expected_cells.pop_front();
        if (got.kind !== want.kind)
          report_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.cell_col !== want.cell_col)
          report_mismatch("cell_col", 32'(got.cell_col), 32'(want.cell_col));
        if (got.cell_row !== want.cell_row)
          report_mismatch("cell_row", 32'(got.cell_row), 32'(want.cell_row));
        if (got.cell_char !== want.cell_char)
          report_mismatch("cell_char", 32'(got.cell_char), 32'(want.cell_char));
        if (got.cell_bg !== want.cell_bg)
          report_mismatch("cell_bg", got.cell_bg, want.cell_bg);
        if (got.cell_fg !== want.cell_fg)
          report_mismatch("cell_fg", got.cell_fg, want.cell_fg);
        if (got.last !== want.last)
          report_mismatch("last", 32'(got.last), 32'(want.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver. Ready drops in about a third of the cycles, never while
  // the full-rate phase runs, and stays low for a long count of cycles when a
  // hold-off is requested, so that the engine fills up and stalls requests.
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_requested != holds_served) begin
        hold_left = HOLD_CYCLES;
        holds_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (no_idle) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run when no transaction of any kind has moved for too
  // long.
  // --------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("[text_console_cursor_engine] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request sender. Valid stays high from one request to the next unless an
  // idle gap is drawn, so it is never lowered and raised in one time step.
  // The prediction runs at the edge where the transaction is accepted.
  // --------------------------------------------------------------------------
  task automatic send_request(tcc_pkg::in_item_t it);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        req_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    do @(posedge clk); while (!req_if.ready);
    predict_console_step(it);
  endtask

  // Lowers valid, waits until every owed result has arrived, then lets the
  // engine finish any trailing request that causes no result.
  task automatic wait_until_drained();
    req_if.valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both geometry registers, back to back, once the engine is idle.
  task automatic set_geometry(logic [7:0] cols, logic [6:0] rows_val);
    tcc_pkg::cfg_item_t wr;
    wait_until_drained();
    wr.index = tcc_pkg::CFG_COLUMNS;
    wr.value = cols;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= wr;
    do @(posedge clk); while (!cfg_if.ready);
    columns_reg = cols;
    wr.index = tcc_pkg::CFG_ROWS;
    wr.value = {1'b0, rows_val};
    cfg_if.data <= wr;
    do @(posedge clk); while (!cfg_if.ready);
    rows_reg = rows_val;
    cfg_if.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Reset geometry: blank store, byte and colour extremes, every control code.
  task automatic test_controls_at_reset();
    send_request(make_read(0, 0));
    send_request(make_read(127, 63));
    send_request(make_put(8'h41, 32'h0000_0000, 32'hFFFF_FFFF));
    send_request(make_put(8'hFF, 32'hFFFF_FFFF, 32'h0000_0000));
    send_request(make_put(8'h00, $urandom, $urandom));
    send_request(make_put(tcc_pkg::CH_BS, $urandom, $urandom));
    send_request(make_put(tcc_pkg::CH_DEL, $urandom, $urandom));
    send_request(make_put(tcc_pkg::CH_CR, $urandom, $urandom));
    // Backspace at column zero does nothing and returns nothing.
    send_request(make_put(tcc_pkg::CH_BS, $urandom, $urandom));
    send_request(make_put(tcc_pkg::CH_TAB, $urandom, $urandom));
    send_request(make_put(tcc_pkg::CH_SPACE, $urandom, $urandom));
    // A tab from column five only pads up to the next stop.
    send_request(make_put(tcc_pkg::CH_TAB, $urandom, $urandom));
    send_request(make_put(tcc_pkg::CH_LF, $urandom, $urandom));
    send_request(make_read(0, 0));
  endtask

  // A tiny grid makes wrap and scroll happen within a few characters.
  task automatic test_wrap_and_scroll();
    set_geometry(8'd4, 7'd2);
    send_request(make_put(8'h61, $urandom, $urandom));
    send_request(make_put(8'h62, $urandom, $urandom));
    send_request(make_put(8'h63, $urandom, $urandom));
    send_request(make_put(8'h64, $urandom, $urandom));
    send_request(make_put(tcc_pkg::CH_LF, $urandom, $urandom));
    send_request(make_read(0, 0));
  endtask

  // Zero registers act as a one-by-one grid: every space of a tab both draws
  // and scrolls, which gives the largest number of results per request.
  task automatic test_zero_geometry();
    set_geometry(8'd0, 7'd0);
    send_request(make_put(8'h78, $urandom, $urandom));
    send_request(make_put(tcc_pkg::CH_TAB, $urandom, $urandom));
    send_request(make_put(tcc_pkg::CH_LF, $urandom, $urandom));
    send_request(make_read(0, 0));
  endtask

  // Random traffic over a range of geometries, the oversized and maximum
  // ones among them. Changing size between phases also leaves the cursor
  // outside the grid now and then, which the next put has to pull back.
  task automatic test_random_traffic();
    logic [7:0] col_set [7];
    logic [6:0] row_set [7];
    col_set = '{8'd3, 8'd255, 8'd1, 8'd16, 8'd128, 8'd7, 8'd0};
    row_set = '{7'd2, 7'd127, 7'd5, 7'd4, 7'd64, 7'd1, 7'd3};
    for (int p = 0; p < 7; p++) begin
      set_geometry(col_set[p], row_set[p]);
      repeat (12) send_request(make_random_item());
    end
    set_geometry(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    repeat (12) send_request(make_random_item());
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the output stage fills and the engine stops accepting.
  task automatic test_result_backpressure();
    set_geometry(8'd5, 7'd3);
    holds_requested++;
    repeat (20) send_request(make_random_item());
  endtask

  // A long stretch at full rate on both sides.
  task automatic test_full_rate();
    set_geometry(8'd8, 7'd3);
    no_idle = 1'b1;
    repeat (40) send_request(make_random_item());
    wait_until_drained();
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    mismatch_count  = 0;
    no_idle         = 1'b0;
    holds_requested = 0;
    clear_grid();
    cur_col     = 0;
    cur_row     = 0;
    columns_reg = tcc_pkg::COLUMNS_RST;
    rows_reg    = tcc_pkg::ROWS_RST;

    rst          <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_controls_at_reset();
    test_wrap_and_scroll();
    test_zero_geometry();
    test_random_traffic();
    test_result_backpressure();
    test_full_rate();
    wait_until_drained();

    if (mismatch_count == 0 && expected_cells.size() == 0) begin
      $display("[text_console_cursor_engine] OK");
    end else begin
      $display("[text_console_cursor_engine] ERROR");
    end
    $finish;
  end

endmodule
